// File: src/diff_drive_pd_slew_regulator_assert.svh
// Assertion macros for the slew regulator checker.
// Each macro takes a label, an antecedent, a consequent and a message.
// They expect clk and rst_n in the scope where they are used.
`ifndef DIFF_DRIVE_PD_SLEW_REGULATOR_ASSERT_SVH
`define DIFF_DRIVE_PD_SLEW_REGULATOR_ASSERT_SVH

// same-cycle implication
`define DDPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// next-cycle implication
`define DDPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ddps_pkg.sv
package ddps_pkg;

    // field widths and fixed-point formats
    localparam int DATA_WIDTH      = 32;
    localparam int DUTY_WIDTH      = 16;
    localparam int DATA_FRAC       = 16;
    localparam int GAIN_FRAC       = 16;
    localparam int GAIN_WIDTH      = 24;
    localparam int DELTA_WIDTH     = 15;
    localparam int DELTA_FRAC      = 15;
    localparam int LIMIT_WIDTH     = 31;
    localparam int CFG_DATA_WIDTH  = 31;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam int ERR_WIDTH  = DATA_WIDTH + 1;
    localparam int PROD_WIDTH = ERR_WIDTH + GAIN_WIDTH;
    localparam int SUM_WIDTH  = PROD_WIDTH + 2;
    localparam int DUTY_FRAC  = DUTY_WIDTH - 1;
    localparam int CONV_SHIFT = DATA_FRAC + GAIN_FRAC - DUTY_FRAC;
    localparam int SHR_WIDTH  = SUM_WIDTH - CONV_SHIFT;

    // max_delta rescaled from Q0.15 to the duty fraction
    localparam int DLT_SHL   = (DUTY_FRAC >= DELTA_FRAC) ? DUTY_FRAC - DELTA_FRAC : 0;
    localparam int DLT_SHR   = (DUTY_FRAC >= DELTA_FRAC) ? 0 : DELTA_FRAC - DUTY_FRAC;
    localparam int DLT_WIDTH = DELTA_WIDTH + DLT_SHL;
    localparam int SLW_WIDTH = ((DUTY_WIDTH > DLT_WIDTH) ? DUTY_WIDTH : DLT_WIDTH) + 2;

    // register reset values
    localparam logic [GAIN_WIDTH-1:0]  KP_TRANS_RST   = 24'd1638400;
    localparam logic [GAIN_WIDTH-1:0]  KV_TRANS_RST   = 24'd65536;
    localparam logic [GAIN_WIDTH-1:0]  KP_ROT_RST     = 24'd183501;
    localparam logic [GAIN_WIDTH-1:0]  KV_ROT_RST     = 24'd3277;
    localparam logic [DELTA_WIDTH-1:0] MAX_DELTA_RST  = 15'd3277;
    localparam logic [LIMIT_WIDTH-1:0] SLIP_TRANS_RST = 31'd1311;
    localparam logic [LIMIT_WIDTH-1:0] SLIP_ROT_RST   = 31'd6554;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_KP_TRANS   = 3'd0,
        CFG_KV_TRANS   = 3'd1,
        CFG_KP_ROT     = 3'd2,
        CFG_KV_ROT     = 3'd3,
        CFG_MAX_DELTA  = 3'd4,
        CFG_SLIP_TRANS = 3'd5,
        CFG_SLIP_ROT   = 3'd6
    } cfg_reg_t;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [ERR_WIDTH-1:0]  err_t;
    typedef logic signed [PROD_WIDTH-1:0] prod_t;
    typedef logic signed [SUM_WIDTH-1:0]  sum_t;
    typedef logic signed [DUTY_WIDTH-1:0] duty_t;
    typedef logic [GAIN_WIDTH-1:0]        gain_t;

    localparam logic signed [SHR_WIDTH-1:0] Q_MAX = SHR_WIDTH'((2 ** (DUTY_WIDTH - 1)) - 1);
    localparam logic signed [SHR_WIDTH-1:0] Q_MIN = SHR_WIDTH'(-(2 ** (DUTY_WIDTH - 1)));

    // signed error times unsigned gain, exact
    function automatic prod_t gain_mul(input err_t e, input gain_t g);
        prod_t pe;
        prod_t pg;
        begin
            pe = PROD_WIDTH'(e);
            pg = $signed(PROD_WIDTH'(g));
            gain_mul = pe * pg;
        end
    endfunction

    // floor to the duty LSB, then clamp to the duty range
    function automatic duty_t sat_duty(input sum_t s);
        logic signed [SHR_WIDTH-1:0] q;
        begin
            q = SHR_WIDTH'(s >>> CONV_SHIFT);
            if (q > Q_MAX)
            begin
                sat_duty = DUTY_WIDTH'(Q_MAX);
            end
            else if (q < Q_MIN)
            begin
                sat_duty = DUTY_WIDTH'(Q_MIN);
            end
            else
            begin
                sat_duty = DUTY_WIDTH'(q);
            end
        end
    endfunction

    // keep duty within delta of the previous duty
    function automatic duty_t slew(input duty_t d, input duty_t last,
                                   input logic [DELTA_WIDTH-1:0] md);
        logic [DLT_WIDTH-1:0]        dl;
        logic signed [SLW_WIDTH-1:0] ds;
        logic signed [SLW_WIDTH-1:0] lw;
        logic signed [SLW_WIDTH-1:0] diff;
        begin
            dl   = (DLT_WIDTH'(md) << DLT_SHL) >> DLT_SHR;
            ds   = $signed(SLW_WIDTH'(dl));
            lw   = SLW_WIDTH'(last);
            diff = SLW_WIDTH'(d) - lw;
            if (diff > ds)
            begin
                slew = DUTY_WIDTH'(lw + ds);
            end
            else if (-diff > ds)
            begin
                slew = DUTY_WIDTH'(lw - ds);
            end
            else
            begin
                slew = d;
            end
        end
    endfunction

    // |e| > lim, with |e| taken as unsigned so the most negative error works
    function automatic logic abs_gt(input err_t e, input logic [LIMIT_WIDTH-1:0] lim);
        logic [ERR_WIDTH-1:0] mag;
        begin
            mag    = e[ERR_WIDTH-1] ? ERR_WIDTH'(-e) : ERR_WIDTH'(e);
            abs_gt = mag > ERR_WIDTH'(lim);
        end
    endfunction

endpackage

// File: src/diff_drive_pd_slew_regulator.sv
// Differential-drive PD regulator with duty slew limiting. Each input request
// is one control tick holding target and measured translation/rotation
// positions and velocities (signed Q16.16). The block forms the four errors,
// applies the Q8.16 gains (trans = kp_trans*e_pos + kv_trans*e_vel, rot the
// same with the rotation gains), mixes right = trans + rot and left =
// trans - rot, floors and saturates each side to Q1.15, and limits each duty
// to within max_delta of the previous duty delivered on that side. The slip
// flag is set when either absolute position error strictly exceeds its limit.
// Rate: one request per clock, sustained while out_stall stays low. A request
// passes through four registers in order: error subtract, the four gain
// multipliers, mix and saturate, then slew limit into the output register.
// Each stage moves whenever the stage after it is empty or moving, so the
// input keeps flowing while a result waits, until all four stages fill.
// Gains and limits are written through the cfg port (index 0..6 in the order
// kp_trans, kv_trans, kp_rot, kv_rot, max_delta, slip_limit_trans,
// slip_limit_rot; other indexes are dropped); cfg_ready is always high and
// writes belong only to idle periods. The previous duties reset to zero.
module diff_drive_pd_slew_regulator
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // config write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ddps_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [ddps_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    // input requests
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [ddps_pkg::DATA_WIDTH-1:0] target_pos_trans,
    input  logic signed [ddps_pkg::DATA_WIDTH-1:0] measured_pos_trans,
    input  logic signed [ddps_pkg::DATA_WIDTH-1:0] target_pos_rot,
    input  logic signed [ddps_pkg::DATA_WIDTH-1:0] measured_pos_rot,
    input  logic signed [ddps_pkg::DATA_WIDTH-1:0] target_vel_trans,
    input  logic signed [ddps_pkg::DATA_WIDTH-1:0] measured_vel_trans,
    input  logic signed [ddps_pkg::DATA_WIDTH-1:0] target_vel_rot,
    input  logic signed [ddps_pkg::DATA_WIDTH-1:0] measured_vel_rot,
    // result requests
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [ddps_pkg::DUTY_WIDTH-1:0] duty_right,
    output logic signed [ddps_pkg::DUTY_WIDTH-1:0] duty_left,
    output logic                                  slip_detected
);

    // ---------------- configuration registers ----------------
    ddps_pkg::gain_t                        kp_trans_reg;
    ddps_pkg::gain_t                        kv_trans_reg;
    ddps_pkg::gain_t                        kp_rot_reg;
    ddps_pkg::gain_t                        kv_rot_reg;
    logic [ddps_pkg::DELTA_WIDTH-1:0]       max_delta_reg;
    logic [ddps_pkg::LIMIT_WIDTH-1:0]       slip_trans_reg;
    logic [ddps_pkg::LIMIT_WIDTH-1:0]       slip_rot_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_trans_reg   <= ddps_pkg::KP_TRANS_RST;
            kv_trans_reg   <= ddps_pkg::KV_TRANS_RST;
            kp_rot_reg     <= ddps_pkg::KP_ROT_RST;
            kv_rot_reg     <= ddps_pkg::KV_ROT_RST;
            max_delta_reg  <= ddps_pkg::MAX_DELTA_RST;
            slip_trans_reg <= ddps_pkg::SLIP_TRANS_RST;
            slip_rot_reg   <= ddps_pkg::SLIP_ROT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ddps_pkg::CFG_KP_TRANS:   kp_trans_reg   <= ddps_pkg::GAIN_WIDTH'(cfg_data);
                ddps_pkg::CFG_KV_TRANS:   kv_trans_reg   <= ddps_pkg::GAIN_WIDTH'(cfg_data);
                ddps_pkg::CFG_KP_ROT:     kp_rot_reg     <= ddps_pkg::GAIN_WIDTH'(cfg_data);
                ddps_pkg::CFG_KV_ROT:     kv_rot_reg     <= ddps_pkg::GAIN_WIDTH'(cfg_data);
                ddps_pkg::CFG_MAX_DELTA:  max_delta_reg  <= ddps_pkg::DELTA_WIDTH'(cfg_data);
                ddps_pkg::CFG_SLIP_TRANS: slip_trans_reg <= ddps_pkg::LIMIT_WIDTH'(cfg_data);
                ddps_pkg::CFG_SLIP_ROT:   slip_rot_reg   <= ddps_pkg::LIMIT_WIDTH'(cfg_data);
                default:                  ; // unknown index, write dropped
            endcase
        end
    end

    // ---------------- stage flow control ----------------
    // A stage can take new data when it is empty or its contents move on.
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic rdy_out;
    logic rdy3;
    logic rdy2;
    logic rdy1;

    assign rdy_out  = !out_valid || !out_stall;
    assign rdy3     = !s3_valid_reg || rdy_out;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ---------------- stage 1: errors (33 bit, exact) ----------------
    ddps_pkg::err_t e_pt_reg;
    ddps_pkg::err_t e_pr_reg;
    ddps_pkg::err_t e_vt_reg;
    ddps_pkg::err_t e_vr_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            e_pt_reg <= ddps_pkg::ERR_WIDTH'(target_pos_trans) -
                        ddps_pkg::ERR_WIDTH'(measured_pos_trans);
            e_pr_reg <= ddps_pkg::ERR_WIDTH'(target_pos_rot) -
                        ddps_pkg::ERR_WIDTH'(measured_pos_rot);
            e_vt_reg <= ddps_pkg::ERR_WIDTH'(target_vel_trans) -
                        ddps_pkg::ERR_WIDTH'(measured_vel_trans);
            e_vr_reg <= ddps_pkg::ERR_WIDTH'(target_vel_rot) -
                        ddps_pkg::ERR_WIDTH'(measured_vel_rot);
        end
    end

    // ---------------- stage 2: gain products, slip compare ----------------
    ddps_pkg::prod_t p_pt_reg;
    ddps_pkg::prod_t p_vt_reg;
    ddps_pkg::prod_t p_pr_reg;
    ddps_pkg::prod_t p_vr_reg;
    logic            slip2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2 && s1_valid_reg)
        begin
            p_pt_reg  <= ddps_pkg::gain_mul(e_pt_reg, kp_trans_reg);
            p_vt_reg  <= ddps_pkg::gain_mul(e_vt_reg, kv_trans_reg);
            p_pr_reg  <= ddps_pkg::gain_mul(e_pr_reg, kp_rot_reg);
            p_vr_reg  <= ddps_pkg::gain_mul(e_vr_reg, kv_rot_reg);
            slip2_reg <= ddps_pkg::abs_gt(e_pt_reg, slip_trans_reg) ||
                         ddps_pkg::abs_gt(e_pr_reg, slip_rot_reg);
        end
    end

    // ---------------- stage 3: mix, floor, saturate ----------------
    // The product sums are exact, so flooring the total once is the same
    // as summing the split high/low parts.
    ddps_pkg::sum_t  trans_sum;
    ddps_pkg::sum_t  rot_sum;
    ddps_pkg::duty_t sat_r_reg;
    ddps_pkg::duty_t sat_l_reg;
    logic            slip3_reg;

    assign trans_sum = ddps_pkg::SUM_WIDTH'(p_pt_reg) + ddps_pkg::SUM_WIDTH'(p_vt_reg);
    assign rot_sum   = ddps_pkg::SUM_WIDTH'(p_pr_reg) + ddps_pkg::SUM_WIDTH'(p_vr_reg);

    always_ff @(posedge clk)
    begin
        if (rdy3 && s2_valid_reg)
        begin
            sat_r_reg <= ddps_pkg::sat_duty(trans_sum + rot_sum);
            sat_l_reg <= ddps_pkg::sat_duty(trans_sum - rot_sum);
            slip3_reg <= slip2_reg;
        end
    end

    // ---------------- stage 4: slew limit into the output register ----------
    // The output duty registers double as the previous-duty state: they
    // change only when a new result is loaded.
    ddps_pkg::duty_t duty_right_next;
    ddps_pkg::duty_t duty_left_next;

    assign duty_right_next = ddps_pkg::slew(sat_r_reg, duty_right, max_delta_reg);
    assign duty_left_next  = ddps_pkg::slew(sat_l_reg, duty_left, max_delta_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid     <= 1'b0;
            duty_right    <= '0;
            duty_left     <= '0;
            slip_detected <= 1'b0;
        end
        else if (rdy_out)
        begin
            out_valid <= s3_valid_reg;
            if (s3_valid_reg)
            begin
                duty_right    <= duty_right_next;
                duty_left     <= duty_left_next;
                slip_detected <= slip3_reg;
            end
        end
    end

endmodule

// File: src/ddps_checker.sv
`include "diff_drive_pd_slew_regulator_assert.svh"

module ddps_checker
(
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_stall,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic signed [ddps_pkg::DUTY_WIDTH-1:0] duty_right,
    input logic signed [ddps_pkg::DUTY_WIDTH-1:0] duty_left,
    input logic                                   slip_detected
);

    // stalled result holds
    `DDPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(duty_right) && $stable(duty_left) && $stable(slip_detected),
        "stalled result changed")

    // input backs up only when the output is backed up
    `DDPS_ASSERT_NOW(a_stall_cause, in_stall, (out_valid && out_stall),
        "input stalled with output free")

    // out_valid is high at the pipeline depth after an accepted request
    `DDPS_ASSERT_NOW(a_latency, in_valid && !in_stall, ##4 out_valid,
        "no result after accepted request")

endmodule

bind diff_drive_pd_slew_regulator ddps_checker u_ddps_checker (.*);

// File: bench/tb_top.sv
`timescale 1ns / 100ps

// Bench for the differential-drive PD regulator.
//
// The in channel carries one control tick per request. The out channel
// returns one duty request per tick: duty_right, duty_left and slip.
//
// A directed table runs first on the reset gains. A few rows carry
// hand-computed duties; the other rows are checked against the local
// model. Then ten gain settings each get a burst of random ticks. The
// settings include all-ones, all-zeros, the defaults, and random values.
// The gain and max_delta writes carry junk above the register width, and a
// write to the spare index should be dropped.
module tb_top;

    localparam int QUIET_LIMIT = 2000;   // cycles with no handshake at all
    localparam int PIPE_LAT    = 4;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_TICKS = 165;
    // no register behind it
    localparam logic [ddps_pkg::CFG_INDEX_WIDTH-1:0] CFG_SPARE = 3'd7;

    // reset values of the gain/limit registers, Q8.16 / Q0.15 / Q15.16
    localparam ddps_pkg::gain_t                   KP_TR_INIT  = 24'd1638400;
    localparam ddps_pkg::gain_t                   KV_TR_INIT  = 24'd65536;
    localparam ddps_pkg::gain_t                   KP_RT_INIT  = 24'd183501;
    localparam ddps_pkg::gain_t                   KV_RT_INIT  = 24'd3277;
    localparam logic [ddps_pkg::DELTA_WIDTH-1:0]  STEP_INIT   = 15'd3277;
    localparam logic [ddps_pkg::LIMIT_WIDTH-1:0]  LIM_TR_INIT = 31'd1311;
    localparam logic [ddps_pkg::LIMIT_WIDTH-1:0]  LIM_RT_INIT = 31'd6554;

    localparam longint DUTY_HI = (longint'(1) << (ddps_pkg::DUTY_WIDTH - 1)) - 1;
    localparam longint DUTY_LO = -DUTY_HI - 1;
    localparam ddps_pkg::data_t DMAX  = 32'sh7FFF_FFFF;
    localparam ddps_pkg::data_t DMIN  = 32'sh8000_0000;
    localparam ddps_pkg::data_t PAT_A = 32'shAAAA_AAAA;
    localparam ddps_pkg::data_t PAT_5 = 32'sh5555_5555;

    typedef struct {
        ddps_pkg::data_t tgt_pos_tr;
        ddps_pkg::data_t msr_pos_tr;
        ddps_pkg::data_t tgt_pos_rt;
        ddps_pkg::data_t msr_pos_rt;
        ddps_pkg::data_t tgt_vel_tr;
        ddps_pkg::data_t msr_vel_tr;
        ddps_pkg::data_t tgt_vel_rt;
        ddps_pkg::data_t msr_vel_rt;
    } tick_t;

    typedef struct {
        ddps_pkg::duty_t right;
        ddps_pkg::duty_t left;
        logic            slip;
    } drive_t;

    typedef struct {
        tick_t  t;
        bit     typed;
        drive_t want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [ddps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [ddps_pkg::CFG_DATA_WIDTH-1:0]  cfg_data = '0;

    logic            in_valid = 1'b0;
    logic            in_stall;
    ddps_pkg::data_t target_pos_trans = '0;
    ddps_pkg::data_t measured_pos_trans = '0;
    ddps_pkg::data_t target_pos_rot = '0;
    ddps_pkg::data_t measured_pos_rot = '0;
    ddps_pkg::data_t target_vel_trans = '0;
    ddps_pkg::data_t measured_vel_trans = '0;
    ddps_pkg::data_t target_vel_rot = '0;
    ddps_pkg::data_t measured_vel_rot = '0;

    logic            out_valid;
    logic            out_stall = 1'b0;
    ddps_pkg::duty_t duty_right;
    ddps_pkg::duty_t duty_left;
    logic            slip_detected;

    // local copy of the registers and of the previous duties
    ddps_pkg::gain_t                  kp_tr = KP_TR_INIT;
    ddps_pkg::gain_t                  kv_tr = KV_TR_INIT;
    ddps_pkg::gain_t                  kp_rt = KP_RT_INIT;
    ddps_pkg::gain_t                  kv_rt = KV_RT_INIT;
    logic [ddps_pkg::DELTA_WIDTH-1:0] slew_step = STEP_INIT;
    logic [ddps_pkg::LIMIT_WIDTH-1:0] slip_lim_tr = LIM_TR_INIT;
    logic [ddps_pkg::LIMIT_WIDTH-1:0] slip_lim_rt = LIM_RT_INIT;
    ddps_pkg::duty_t                  prev_right = '0;
    ddps_pkg::duty_t                  prev_left = '0;

    drive_t pending_drives[$];  // predicted duties, oldest first
    row_t   dir_rows[$];

    int src_gap_pct = 0;        // chance that the sender idles for a cycle
    int sink_stall_pct = 0;     // chance that the receiver stalls for a cycle
    int quiet = 0;
    int mismatches = 0;
    int ticks_sent = 0;
    int slip_seen = 0;
    int slew_hits = 0;

    diff_drive_pd_slew_regulator DUT
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .target_pos_trans   (target_pos_trans),
        .measured_pos_trans (measured_pos_trans),
        .target_pos_rot     (target_pos_rot),
        .measured_pos_rot   (measured_pos_rot),
        .target_vel_trans   (target_vel_trans),
        .measured_vel_trans (measured_vel_trans),
        .target_vel_rot     (target_vel_rot),
        .measured_vel_rot   (measured_vel_rot),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .duty_right         (duty_right),
        .duty_left          (duty_left),
        .slip_detected      (slip_detected)
    );

    always #5 clk = ~clk;

    // ---------------- model ----------------

    function automatic void apply_reg(input logic [ddps_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                      input logic [ddps_pkg::CFG_DATA_WIDTH-1:0] val);
        case (idx)
            ddps_pkg::CFG_KP_TRANS:   kp_tr = val[ddps_pkg::GAIN_WIDTH-1:0];
            ddps_pkg::CFG_KV_TRANS:   kv_tr = val[ddps_pkg::GAIN_WIDTH-1:0];
            ddps_pkg::CFG_KP_ROT:     kp_rt = val[ddps_pkg::GAIN_WIDTH-1:0];
            ddps_pkg::CFG_KV_ROT:     kv_rt = val[ddps_pkg::GAIN_WIDTH-1:0];
            ddps_pkg::CFG_MAX_DELTA:  slew_step = val[ddps_pkg::DELTA_WIDTH-1:0];
            ddps_pkg::CFG_SLIP_TRANS: slip_lim_tr = val[ddps_pkg::LIMIT_WIDTH-1:0];
            ddps_pkg::CFG_SLIP_ROT:   slip_lim_rt = val[ddps_pkg::LIMIT_WIDTH-1:0];
            default: ;
        endcase
    endfunction

    // Q.32 sum -> duty LSBs, floored, then clamped
    function automatic longint to_duty(input longint acc);
        longint q;
        q = acc >>> ddps_pkg::CONV_SHIFT;
        if (q > DUTY_HI)
        begin
            q = DUTY_HI;
        end
        else if (q < DUTY_LO)
        begin
            q = DUTY_LO;
        end
        return q;
    endfunction

    function automatic longint slew_to(input longint aim, input longint last,
                                       input longint step);
        if (aim - last > step)
        begin
            slew_hits++;
            return last + step;
        end
        if (last - aim > step)
        begin
            slew_hits++;
            return last - step;
        end
        return aim;
    endfunction

    // one control tick: errors, PD terms, mix, saturate, slew, slip
    function automatic drive_t regulate(input tick_t t);
        longint e_pt;
        longint e_pr;
        longint e_vt;
        longint e_vr;
        longint trans;
        longint rot;
        longint r;
        longint l;
        drive_t d;
        e_pt  = longint'(t.tgt_pos_tr) - longint'(t.msr_pos_tr);
        e_pr  = longint'(t.tgt_pos_rt) - longint'(t.msr_pos_rt);
        e_vt  = longint'(t.tgt_vel_tr) - longint'(t.msr_vel_tr);
        e_vr  = longint'(t.tgt_vel_rt) - longint'(t.msr_vel_rt);
        trans = e_pt * longint'(kp_tr) + e_vt * longint'(kv_tr);
        rot   = e_pr * longint'(kp_rt) + e_vr * longint'(kv_rt);
        r = slew_to(to_duty(trans + rot), longint'(prev_right), longint'(slew_step));
        l = slew_to(to_duty(trans - rot), longint'(prev_left), longint'(slew_step));
        prev_right = ddps_pkg::duty_t'(r);
        prev_left  = ddps_pkg::duty_t'(l);
        d.right = ddps_pkg::duty_t'(r);
        d.left  = ddps_pkg::duty_t'(l);
        d.slip  = ((e_pt < 0 ? -e_pt : e_pt) > longint'(slip_lim_tr)) ||
                  ((e_pr < 0 ? -e_pr : e_pr) > longint'(slip_lim_rt));
        if (d.slip)
        begin
            slip_seen++;
        end
        return d;
    endfunction

    // ---------------- stimulus ----------------

    function automatic tick_t mk_tick(input ddps_pkg::data_t a, input ddps_pkg::data_t b,
                                      input ddps_pkg::data_t c, input ddps_pkg::data_t d,
                                      input ddps_pkg::data_t e, input ddps_pkg::data_t f,
                                      input ddps_pkg::data_t g, input ddps_pkg::data_t h);
        tick_t t;
        t = '{a, b, c, d, e, f, g, h};
        return t;
    endfunction

    function automatic void add_row(input tick_t t, input bit typed, input drive_t want);
        row_t r;
        r = '{t, typed, want};
        dir_rows.push_back(r);
    endfunction

    // Error magnitudes: mostly small enough to keep the duty out of saturation,
    // some right at the slip limit, some spanning the full range.
    function automatic longint pick_err(input longint lim);
        longint e;
        int     kind;
        kind = $urandom_range(0, 9);
        if (kind < 2)
        begin
            e = lim + longint'($urandom_range(0, 2)) - 1;
        end
        else if (kind < 8)
        begin
            e = longint'($urandom_range(0, (1 << $urandom_range(0, 22)) - 1));
        end
        else if (kind == 8)
        begin
            e = 0;
        end
        else
        begin
            e = longint'(ddps_pkg::data_t'($urandom)) - longint'(ddps_pkg::data_t'($urandom));
        end
        if ($urandom_range(0, 1) == 1)
        begin
            e = -e;
        end
        return e;
    endfunction

    // target/measured pair with the given difference
    function automatic void make_pair(input longint e, output ddps_pkg::data_t tgt,
                                      output ddps_pkg::data_t msr);
        longint base;
        longint m;
        longint half;
        base = longint'(ddps_pkg::data_t'($urandom));
        m    = base - e;
        if (m >= longint'(DMIN) && m <= longint'(DMAX))
        begin
            tgt = ddps_pkg::data_t'(base);
            msr = ddps_pkg::data_t'(m);
        end
        else
        begin
            half = (e + 1) >>> 1;
            tgt  = ddps_pkg::data_t'(e - half);
            msr  = ddps_pkg::data_t'(-half);
        end
    endfunction

    function automatic tick_t make_tick();
        tick_t t;
        if ($urandom_range(0, 99) < 12)
        begin
            t = mk_tick(ddps_pkg::data_t'($urandom), ddps_pkg::data_t'($urandom),
                        ddps_pkg::data_t'($urandom), ddps_pkg::data_t'($urandom),
                        ddps_pkg::data_t'($urandom), ddps_pkg::data_t'($urandom),
                        ddps_pkg::data_t'($urandom), ddps_pkg::data_t'($urandom));
        end
        else
        begin
            make_pair(pick_err(longint'(slip_lim_tr)), t.tgt_pos_tr, t.msr_pos_tr);
            make_pair(pick_err(longint'(slip_lim_rt)), t.tgt_pos_rt, t.msr_pos_rt);
            make_pair(pick_err(0), t.tgt_vel_tr, t.msr_vel_tr);
            make_pair(pick_err(0), t.tgt_vel_rt, t.msr_vel_rt);
        end
        return t;
    endfunction

    // Present one tick request and hold it until taken. A typed row's
    // duties replace the model's; the model still runs to keep its state.
    task automatic push_tick(input tick_t t, input bit typed, input drive_t want);
        drive_t got;
        while ($urandom_range(0, 99) < src_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid           <= 1'b1;
        target_pos_trans   <= t.tgt_pos_tr;
        measured_pos_trans <= t.msr_pos_tr;
        target_pos_rot     <= t.tgt_pos_rt;
        measured_pos_rot   <= t.msr_pos_rt;
        target_vel_trans   <= t.tgt_vel_tr;
        measured_vel_trans <= t.msr_vel_tr;
        target_vel_rot     <= t.tgt_vel_rt;
        measured_vel_rot   <= t.msr_vel_rt;
        do @(posedge clk); while (in_stall);
        got = regulate(t);
        pending_drives.push_back(typed ? want : got);
        ticks_sent++;
    endtask

    // stop sending, let every predicted duty come out, then the pipe settles
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (pending_drives.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    // cfg_valid stays up across a burst of writes; caller drops it
    task automatic write_reg(input logic [ddps_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [ddps_pkg::CFG_DATA_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, val);
    endtask

    // Setting 0 is all ones, 1 all zeros, 2 the reset values, the rest random
    // with a random spread of magnitudes.
    task automatic program_regs(input int phase);
        ddps_pkg::cfg_reg_t                  order [7];
        logic [ddps_pkg::CFG_DATA_WIDTH-1:0] v [7];
        ddps_pkg::gain_t                     g [4];
        logic [ddps_pkg::DELTA_WIDTH-1:0]    dlt;
        logic [ddps_pkg::LIMIT_WIDTH-1:0]    lim [2];
        order = '{ddps_pkg::CFG_KP_TRANS, ddps_pkg::CFG_KV_TRANS,
                  ddps_pkg::CFG_KP_ROT, ddps_pkg::CFG_KV_ROT,
                  ddps_pkg::CFG_MAX_DELTA, ddps_pkg::CFG_SLIP_TRANS,
                  ddps_pkg::CFG_SLIP_ROT};
        case (phase)
            0:
            begin
                g   = '{default: '1};
                dlt = '1;
                lim = '{default: '1};
            end
            1:
            begin
                g   = '{default: '0};
                dlt = '0;
                lim = '{default: '0};
            end
            2:
            begin
                g   = '{KP_TR_INIT, KV_TR_INIT, KP_RT_INIT, KV_RT_INIT};
                dlt = STEP_INIT;
                lim = '{LIM_TR_INIT, LIM_RT_INIT};
            end
            default:
            begin
                foreach (g[k])
                begin
                    g[k] = ddps_pkg::gain_t'($urandom >> $urandom_range(8, 31));
                end
                dlt = ddps_pkg::DELTA_WIDTH'($urandom >> $urandom_range(17, 31));
                foreach (lim[k])
                begin
                    lim[k] = ddps_pkg::LIMIT_WIDTH'($urandom >> $urandom_range(1, 31));
                end
            end
        endcase
        // junk above the register width must be masked off
        foreach (g[k])
        begin
            v[k] = {7'($urandom), g[k]};
        end
        v[4] = {16'($urandom), dlt};
        v[5] = lim[0];
        v[6] = lim[1];
        foreach (order[k])
        begin
            write_reg(order[k], v[k]);
        end
        write_reg(CFG_SPARE, ddps_pkg::CFG_DATA_WIDTH'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Directed rows. Typed duties follow the reset gains with a 0.1 step:
    // a full-scale error walks the duty up by 3277 per tick.
    task automatic fill_directed();
        drive_t nil;
        nil = '{'0, '0, 1'b0};
        add_row(mk_tick(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{16'sd0, 16'sd0, 1'b0});
        // full positive translation error: both sides step up, slip
        add_row(mk_tick(DMAX, DMIN, 0, 0, 0, 0, 0, 0), 1'b1, '{16'sd3277, 16'sd3277, 1'b1});
        add_row(mk_tick(DMAX, DMIN, 0, 0, 0, 0, 0, 0), 1'b1, '{16'sd6554, 16'sd6554, 1'b1});
        // full negative rotation error: right steps down, left up
        add_row(mk_tick(0, 0, DMIN, DMAX, 0, 0, 0, 0), 1'b1, '{16'sd3277, 16'sd9831, 1'b1});
        // zero error at both ends of the range: duties head back to zero
        add_row(mk_tick(DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX), 1'b1,
                '{16'sd0, 16'sd6554, 1'b0});
        add_row(mk_tick(DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN), 1'b1,
                '{16'sd0, 16'sd3277, 1'b0});
        // slip is strict: at the limit no, one past it yes, both signs
        add_row(mk_tick(32'sd1311, 0, 0, 0, 0, 0, 0, 0), 1'b0, nil);
        add_row(mk_tick(32'sd1312, 0, 0, 0, 0, 0, 0, 0), 1'b0, nil);
        add_row(mk_tick(0, 32'sd1311, 0, 0, 0, 0, 0, 0), 1'b0, nil);
        add_row(mk_tick(0, 32'sd1312, 0, 0, 0, 0, 0, 0), 1'b0, nil);
        add_row(mk_tick(0, 0, 32'sd6554, 0, 0, 0, 0, 0), 1'b0, nil);
        add_row(mk_tick(0, 0, 32'sd6555, 0, 0, 0, 0, 0), 1'b0, nil);
        add_row(mk_tick(0, 0, 0, 32'sd6555, 0, 0, 0, 0), 1'b0, nil);
        // velocity extremes
        add_row(mk_tick(0, 0, 0, 0, DMAX, DMIN, DMIN, DMAX), 1'b0, nil);
        add_row(mk_tick(0, 0, 0, 0, DMIN, DMAX, DMAX, DMIN), 1'b0, nil);
        // floor, not truncation, for small negative sums
        add_row(mk_tick(-32'sd1, 0, 0, 0, 0, 0, 0, 0), 1'b0, nil);
        add_row(mk_tick(0, 0, 0, 0, 32'sd1, 0, 0, 0), 1'b0, nil);
        add_row(mk_tick(0, 0, 0, 0, 0, 32'sd1, 0, 0), 1'b0, nil);
        add_row(mk_tick(PAT_A, PAT_5, PAT_5, PAT_A, PAT_A, PAT_5, PAT_5, PAT_A), 1'b0, nil);
        add_row(mk_tick(PAT_5, PAT_A, PAT_A, PAT_5, PAT_5, PAT_A, PAT_A, PAT_5), 1'b0, nil);
        add_row(mk_tick(32'sd100, -32'sd100, 32'sd3000, -32'sd3000,
                        32'sd65536, 0, -32'sd65536, 0), 1'b0, nil);
        add_row(mk_tick(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, nil);
    endtask

    // ---------------- receiver and checker ----------------

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    always @(posedge clk)
    begin
        drive_t want;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
            begin
                quiet <= 0;
            end
            else
            begin
                quiet <= quiet + 1;
            end
            if (out_valid && !out_stall)
            begin
                if (pending_drives.size() == 0)
                begin
                    $display("%0t: duty request with none expected (%0d, %0d, %0b)",
                             $time, duty_right, duty_left, slip_detected);
                    mismatches++;
                end
                else
                begin
                    want = pending_drives.pop_front();
                    if (duty_right !== want.right)
                    begin
                        $display("%0t: duty_right expected %0d got %0d",
                                 $time, want.right, duty_right);
                        mismatches++;
                    end
                    if (duty_left !== want.left)
                    begin
                        $display("%0t: duty_left expected %0d got %0d",
                                 $time, want.left, duty_left);
                        mismatches++;
                    end
                    if (slip_detected !== want.slip)
                    begin
                        $display("%0t: slip_detected expected %0b got %0b",
                                 $time, want.slip, slip_detected);
                        mismatches++;
                    end
                end
            end
        end
    end

    // nothing moved on any channel for too long
    initial
    begin
        wait (rst_n === 1'b1);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
        end
        $display("%0t: no handshake for %0d cycles, %0d duties outstanding",
                 $time, QUIET_LIMIT, pending_drives.size());
        $display("tb_top NOT OK");
        $finish;
    end

    // ---------------- sequence ----------------

    initial
    begin
        drive_t nil;
        nil = '{'0, '0, 1'b0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // light sender gaps, heavy receiver stalls
        src_gap_pct    = 19;
        sink_stall_pct = 85;
        fill_directed();
        foreach (dir_rows[i])
        begin
            push_tick(dir_rows[i].t, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            // registers change only with the pipe empty
            drain_pipe();
            program_regs(p);
            if (p == 4)
            begin
                src_gap_pct    = 85;
                sink_stall_pct = 19;
            end
            else if (p == 7)
            begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            repeat (PHASE_TICKS) push_tick(make_tick(), 1'b0, nil);
        end
        drain_pipe();

        $display("Covered %0d control ticks over %0d register settings: %0d with slip,",
                 ticks_sent, RAND_PHASES + 1, slip_seen);
        $display("%0d duty steps clipped by the slew limit, %0d mismatches.",
                 slew_hits, mismatches);
        if (mismatches == 0 && pending_drives.size() == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
